>>> design/httc_pkg.sv
`timescale 1ns / 1ps

package httc_pkg;

    localparam int CHANNELS     = 2;
    localparam int CHAN_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HANDLE_W     = 32;
    localparam int CHAN_SHIFT   = 28;
    localparam int TOP_W        = HANDLE_W - CHAN_SHIFT;
    localparam int ARG_W        = 32;
    localparam int NS_W         = 32;
    localparam int TIMER_W      = 16;
    localparam int MAX_EVENTS   = 2;
    localparam int EVENT_CNT_W  = 2;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_W        = 32;
    localparam logic [CFG_W-1:0] MIN_SINGLE_RESET = 32'd5000;
    localparam logic [CFG_W-1:0] MIN_CYCLE_RESET  = 32'd100000;

    localparam int NS_PER_COUNT = 2304;
    localparam logic [TIMER_W-1:0] MAX_COUNT = 16'hFFFF;
    localparam longint OVER_NS_L = (longint'(MAX_COUNT) + 1) * NS_PER_COUNT;
    localparam logic [NS_W-1:0] OVER_NS = OVER_NS_L[NS_W-1:0];

    // 2304 = 256 * 9: shift by 8, then multiply by a reciprocal of 9
    localparam int PRE_SHIFT    = 8;
    localparam int DIV_REST     = NS_PER_COUNT >> PRE_SHIFT;
    localparam int DIV_IN_W     = CHAN_SHIFT - PRE_SHIFT;
    localparam int RECIP_SHIFT  = 23;
    localparam int RECIP_W      = 24;
    localparam int RECIP_INT    = ((1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_INT[RECIP_W-1:0];

    typedef enum logic [1:0] {
        MODE_MODIFY = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_NOT_CREATED = 2'd2
    } status_t;

    typedef enum logic {
        KIND_REPLY  = 1'b0,
        KIND_EXPIRY = 1'b1
    } kind_t;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SINGLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_CYCLE  = 2'd1;

    typedef struct packed {
        logic               over;
        logic [TIMER_W-1:0] target;
    } count_t;

    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [ARG_W-1:0]    argument;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [EVENT_CNT_W-1:0]         n;
        result_t [MAX_EVENTS-1:0]       slot;
    } bank_out_t;

endpackage

>>> design/handle_tagged_timer_channels.sv
`timescale 1ns / 1ps

// channel   direction  handshake           fields
// command   in         start, busy         mode, handle_in, timeout_ns, continuous, argument
// result    out        done (one cycle)    kind, status, handle_out, argument_out, last
// config    in         cfg_wr_en           cfg_index, cfg_data
//
// a command is taken when start is high and busy low; its results appear
// on the next cycle, one item per cycle, each marked by done for one cycle.
// modify, delete and ticks with at most one expiry never raise busy; a tick
// with two expiries holds busy while the second item goes out.
// rst_n is asynchronous: all channels free and stopped, limits at reset values.
// the receiver cannot stall: done items must be taken when shown.

module handle_tagged_timer_channels
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [httc_pkg::HANDLE_W-1:0]     handle_in,
    input  logic [httc_pkg::NS_W-1:0]         timeout_ns,
    input  logic                              continuous,
    input  logic [httc_pkg::ARG_W-1:0]        argument,
    input  logic                              cfg_wr_en,
    input  logic [httc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [httc_pkg::CFG_W-1:0]        cfg_data,
    output logic                              done,
    output logic                              kind,
    output logic [1:0]                        status,
    output logic [httc_pkg::HANDLE_W-1:0]     handle_out,
    output logic [httc_pkg::ARG_W-1:0]        argument_out,
    output logic                              last
);

    logic                accept;
    logic                pend_vld;
    httc_pkg::count_t    count;
    httc_pkg::bank_out_t bank_out;
    httc_pkg::result_t   out_res;

    assign accept = start && !busy;
    assign busy   = pend_vld;

    httc_timeout_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .timeout_ns (timeout_ns),
        .continuous (continuous),
        .count      (count)
    );

    httc_channel_bank u_bank
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .handle_in  (handle_in),
        .continuous (continuous),
        .argument   (argument),
        .count      (count),
        .bank_out   (bank_out)
    );

    httc_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .bank_out (bank_out),
        .out_vld  (done),
        .out_res  (out_res),
        .pend_vld (pend_vld)
    );

    assign kind         = out_res.kind;
    assign status       = out_res.status;
    assign handle_out   = out_res.handle;
    assign argument_out = out_res.argument;
    assign last         = out_res.last;

`ifndef SYNTHESIS
    a_busy_means_output: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> done)
        else $error("pending item without a shown item");

    a_not_last_followed: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && last)
        else $error("second item of a tick missing");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("busy after the last item");

    a_command_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == httc_pkg::MODE_MODIFY || mode == httc_pkg::MODE_DELETE)
        |=> done && last && kind == httc_pkg::KIND_REPLY)
        else $error("command without reply");
`endif

endmodule

>>> design/httc_timeout_scale.sv
`timescale 1ns / 1ps

module httc_timeout_scale
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [httc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [httc_pkg::CFG_W-1:0]        cfg_data,
    input  logic [httc_pkg::NS_W-1:0]         timeout_ns,
    input  logic                              continuous,
    output httc_pkg::count_t                  count
);

    logic [httc_pkg::CFG_W-1:0] min_single_reg;
    logic [httc_pkg::CFG_W-1:0] min_cycle_reg;
    logic [httc_pkg::NS_W-1:0]  t_ns;
    logic [httc_pkg::DIV_IN_W-1:0] div_in;
    logic [httc_pkg::DIV_IN_W+httc_pkg::RECIP_W-1:0] product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_single_reg <= httc_pkg::MIN_SINGLE_RESET;
            min_cycle_reg  <= httc_pkg::MIN_CYCLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == httc_pkg::REG_MIN_SINGLE)
            begin
                min_single_reg <= cfg_data;
            end
            if (cfg_index == httc_pkg::REG_MIN_CYCLE)
            begin
                min_cycle_reg <= cfg_data;
            end
        end
    end

    // raise to the mode minimum
    always_comb
    begin
        if (continuous)
        begin
            t_ns = (timeout_ns < min_cycle_reg) ? min_cycle_reg : timeout_ns;
        end
        else
        begin
            t_ns = (timeout_ns < min_single_reg) ? min_single_reg : timeout_ns;
        end
    end

    // below the overflow bound the value fits in 28 bits
    assign div_in  = t_ns[httc_pkg::CHAN_SHIFT-1:httc_pkg::PRE_SHIFT];
    assign product = (httc_pkg::DIV_IN_W+httc_pkg::RECIP_W)'(div_in)
                   * (httc_pkg::DIV_IN_W+httc_pkg::RECIP_W)'(httc_pkg::RECIP_MUL);

    assign count.over   = (t_ns >= httc_pkg::OVER_NS);
    assign count.target = product[httc_pkg::RECIP_SHIFT +: httc_pkg::TIMER_W];

endmodule

>>> design/httc_channel_bank.sv
`timescale 1ns / 1ps

module httc_channel_bank
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [1:0]                     mode,
    input  logic [httc_pkg::HANDLE_W-1:0]  handle_in,
    input  logic                           continuous,
    input  logic [httc_pkg::ARG_W-1:0]     argument,
    input  httc_pkg::count_t               count,
    output httc_pkg::bank_out_t            bank_out
);

    localparam int CH = httc_pkg::CHANNELS;

    logic [httc_pkg::HANDLE_W-1:0] handle_reg   [CH];
    logic [httc_pkg::HANDLE_W-1:0] handle_next  [CH];
    logic [httc_pkg::ARG_W-1:0]    arg_reg      [CH];
    logic [httc_pkg::ARG_W-1:0]    arg_next     [CH];
    logic                          periodic_reg [CH];
    logic                          periodic_next[CH];
    logic                          running_reg  [CH];
    logic                          running_next [CH];
    logic [httc_pkg::TIMER_W-1:0]  target_reg   [CH];
    logic [httc_pkg::TIMER_W-1:0]  target_next  [CH];
    logic [httc_pkg::TIMER_W-1:0]  count_reg    [CH];
    logic [httc_pkg::TIMER_W-1:0]  count_next   [CH];

    httc_pkg::mode_t               cmd;
    logic [httc_pkg::TOP_W-1:0]    top;
    logic                          top_valid;
    logic [httc_pkg::CHAN_W-1:0]   chan_idx;
    logic                          free_found;
    logic [httc_pkg::CHAN_W-1:0]   free_idx;
    logic                          go;
    logic [httc_pkg::CHAN_W-1:0]   sel;
    logic [httc_pkg::HANDLE_W-1:0] base;
    logic [httc_pkg::HANDLE_W-1:0] new_handle;
    logic [httc_pkg::TIMER_W:0]    inc;
    logic [httc_pkg::EVENT_CNT_W-1:0] n;
    httc_pkg::result_t             ev;

    assign cmd       = httc_pkg::mode_t'(mode);
    assign top       = handle_in[httc_pkg::HANDLE_W-1:httc_pkg::CHAN_SHIFT];
    assign top_valid = (top != '0) && (top <= httc_pkg::TOP_W'(CH));
    assign chan_idx  = httc_pkg::CHAN_W'(top - httc_pkg::TOP_W'(1));

    // lowest free channel
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CH - 1; i >= 0; i--)
        begin
            if (handle_reg[i] == '0)
            begin
                free_found = 1'b1;
                free_idx   = httc_pkg::CHAN_W'(i);
            end
        end
    end

    always_comb
    begin
        handle_next   = handle_reg;
        arg_next      = arg_reg;
        periodic_next = periodic_reg;
        running_next  = running_reg;
        target_next   = target_reg;
        count_next    = count_reg;
        bank_out      = '0;
        go            = 1'b0;
        sel           = '0;
        base          = '0;
        new_handle    = '0;
        inc           = '0;
        n             = '0;
        ev            = '0;

        if (accept)
        begin
            unique case (cmd)
                httc_pkg::MODE_MODIFY:
                begin
                    bank_out.n             = httc_pkg::EVENT_CNT_W'(1);
                    bank_out.slot[0].kind  = httc_pkg::KIND_REPLY;
                    bank_out.slot[0].last  = 1'b1;
                    if (handle_in == '0)
                    begin
                        if (free_found)
                        begin
                            go  = 1'b1;
                            sel = free_idx;
                        end
                        else
                        begin
                            bank_out.slot[0].status = httc_pkg::ST_NOT_CREATED;
                        end
                    end
                    else if (top_valid)
                    begin
                        go  = 1'b1;
                        sel = chan_idx;
                    end
                    else
                    begin
                        bank_out.slot[0].status = httc_pkg::ST_INVALID;
                        bank_out.slot[0].handle = handle_in;
                    end

                    if (go)
                    begin
                        if (handle_reg[sel] == '0)
                        begin
                            base = {httc_pkg::TOP_W'(sel) + httc_pkg::TOP_W'(1),
                                    {httc_pkg::CHAN_SHIFT{1'b0}}};
                        end
                        else
                        begin
                            base = handle_reg[sel];
                        end
                        // generation advances with wrap, channel nibble kept
                        new_handle = {base[httc_pkg::HANDLE_W-1:httc_pkg::CHAN_SHIFT],
                                      base[httc_pkg::CHAN_SHIFT-1:0]
                                      + httc_pkg::CHAN_SHIFT'(1)};
                        handle_next[sel]        = new_handle;
                        bank_out.slot[0].handle = new_handle;
                        if (count.over)
                        begin
                            bank_out.slot[0].status = httc_pkg::ST_NOT_CREATED;
                        end
                        else
                        begin
                            bank_out.slot[0].status = httc_pkg::ST_OK;
                            arg_next[sel]      = argument;
                            periodic_next[sel] = continuous;
                            target_next[sel]   = count.target;
                            count_next[sel]    = '0;
                            running_next[sel]  = 1'b1;
                        end
                    end
                end

                httc_pkg::MODE_DELETE:
                begin
                    bank_out.n             = httc_pkg::EVENT_CNT_W'(1);
                    bank_out.slot[0].kind  = httc_pkg::KIND_REPLY;
                    bank_out.slot[0].last  = 1'b1;
                    bank_out.slot[0].status = httc_pkg::ST_OK;
                    if (handle_in == '0)
                    begin
                        bank_out.slot[0].handle = '0;
                    end
                    else if (!top_valid)
                    begin
                        bank_out.slot[0].status = httc_pkg::ST_INVALID;
                        bank_out.slot[0].handle = handle_in;
                    end
                    else if (handle_reg[chan_idx] != handle_in)
                    begin
                        bank_out.slot[0].handle = handle_in;
                    end
                    else
                    begin
                        handle_next[chan_idx]   = '0;
                        running_next[chan_idx]  = 1'b0;
                        bank_out.slot[0].handle = '0;
                    end
                end

                httc_pkg::MODE_TICK:
                begin
                    for (int i = 0; i < CH; i++)
                    begin
                        if (running_reg[i])
                        begin
                            inc = {1'b0, count_reg[i]} + (httc_pkg::TIMER_W+1)'(1);
                            if (inc >= {1'b0, target_reg[i]})
                            begin
                                // channels past the event limit hold their count
                                if (n < httc_pkg::EVENT_CNT_W'(httc_pkg::MAX_EVENTS))
                                begin
                                    ev.kind     = httc_pkg::KIND_EXPIRY;
                                    ev.status   = httc_pkg::ST_OK;
                                    ev.handle   = handle_reg[i];
                                    ev.argument = arg_reg[i];
                                    ev.last     = 1'b0;
                                    if (n == '0)
                                    begin
                                        bank_out.slot[0] = ev;
                                    end
                                    else
                                    begin
                                        bank_out.slot[1] = ev;
                                    end
                                    n             = n + httc_pkg::EVENT_CNT_W'(1);
                                    count_next[i] = '0;
                                    if (!periodic_reg[i])
                                    begin
                                        running_next[i] = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                count_next[i] = inc[httc_pkg::TIMER_W-1:0];
                            end
                        end
                    end
                    bank_out.n = n;
                    if (n == httc_pkg::EVENT_CNT_W'(1))
                    begin
                        bank_out.slot[0].last = 1'b1;
                    end
                    else if (n == httc_pkg::EVENT_CNT_W'(2))
                    begin
                        bank_out.slot[1].last = 1'b1;
                    end
                end

                default:
                begin
                    bank_out = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH; i++)
            begin
                handle_reg[i]  <= '0;
                running_reg[i] <= 1'b0;
            end
        end
        else
        begin
            handle_reg  <= handle_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg      <= arg_next;
        periodic_reg <= periodic_next;
        target_reg   <= target_next;
        count_reg    <= count_next;
    end

endmodule

>>> design/httc_result_queue.sv
`timescale 1ns / 1ps

module httc_result_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  httc_pkg::bank_out_t  bank_out,
    output logic                 out_vld,
    output httc_pkg::result_t    out_res,
    output logic                 pend_vld
);

    logic              out_vld_reg;
    logic              out_vld_next;
    logic              pend_vld_reg;
    logic              pend_vld_next;
    httc_pkg::result_t out_res_reg;
    httc_pkg::result_t out_res_next;
    httc_pkg::result_t pend_res_reg;
    httc_pkg::result_t pend_res_next;

    always_comb
    begin
        out_vld_next  = 1'b0;
        pend_vld_next = 1'b0;
        out_res_next  = out_res_reg;
        pend_res_next = pend_res_reg;
        if (accept)
        begin
            out_vld_next  = (bank_out.n != '0);
            pend_vld_next = (bank_out.n == httc_pkg::EVENT_CNT_W'(2));
            out_res_next  = bank_out.slot[0];
            pend_res_next = bank_out.slot[1];
        end
        else if (pend_vld_reg)
        begin
            // second item of a tick goes out the cycle after the first
            out_vld_next = 1'b1;
            out_res_next = pend_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_vld  = out_vld_reg;
    assign out_res  = out_res_reg;
    assign pend_vld = pend_vld_reg;

endmodule

>>> test/tb_handle_tagged_timer_channels.sv
`timescale 1ns / 1ps

module tb_handle_tagged_timer_channels;

    localparam logic [httc_pkg::HANDLE_W-1:0] GEN_MASK = 32'h0FFF_FFFF;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam logic [httc_pkg::NS_W-1:0] FIRST_OVER_NS = 32'd150994944;

    class timer_bank_tracker;

        logic [httc_pkg::CFG_W-1:0]    min_single;
        logic [httc_pkg::CFG_W-1:0]    min_cycle;
        logic [httc_pkg::HANDLE_W-1:0] chan_handle [httc_pkg::CHANNELS];
        logic [httc_pkg::ARG_W-1:0]    chan_arg [httc_pkg::CHANNELS];
        logic                          chan_periodic [httc_pkg::CHANNELS];
        logic                          chan_running [httc_pkg::CHANNELS];
        logic [httc_pkg::TIMER_W-1:0]  chan_target [httc_pkg::CHANNELS];
        logic [httc_pkg::TIMER_W-1:0]  chan_count [httc_pkg::CHANNELS];
        httc_pkg::result_t             due_results [$];
        int                            errors;

        function new();
            int i;
            errors = 0;
            min_single = httc_pkg::MIN_SINGLE_RESET;
            min_cycle = httc_pkg::MIN_CYCLE_RESET;
            for (i = 0; i < httc_pkg::CHANNELS; i++)
            begin
                chan_handle[i] = '0;
                chan_arg[i] = '0;
                chan_periodic[i] = 1'b0;
                chan_running[i] = 1'b0;
                chan_target[i] = '0;
                chan_count[i] = '0;
            end
        endfunction

        function void write_reg(logic [httc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [httc_pkg::CFG_W-1:0] data);
            if (idx == httc_pkg::REG_MIN_SINGLE)
                min_single = data;
            else if (idx == httc_pkg::REG_MIN_CYCLE)
                min_cycle = data;
        endfunction

        function httc_pkg::result_t reply(httc_pkg::status_t st,
                                          logic [httc_pkg::HANDLE_W-1:0] h);
            httc_pkg::result_t r;
            r.kind = httc_pkg::KIND_REPLY;
            r.status = st;
            r.handle = h;
            r.argument = '0;
            r.last = 1'b1;
            return r;
        endfunction

        function void take_command(logic [1:0] md, logic [httc_pkg::HANDLE_W-1:0] hin,
                                   logic [httc_pkg::NS_W-1:0] tns, logic cont,
                                   logic [httc_pkg::ARG_W-1:0] arg);
            int c;
            int i;
            int n;
            logic [httc_pkg::TOP_W-1:0] top;
            logic [httc_pkg::HANDLE_W-1:0] h;
            logic [httc_pkg::NS_W-1:0] t;
            logic [httc_pkg::NS_W-1:0] cnt;
            logic [httc_pkg::TIMER_W:0] nxt;
            httc_pkg::result_t ev;
            c = -1;
            n = 0;
            top = hin[httc_pkg::HANDLE_W-1:httc_pkg::CHAN_SHIFT];
            case (md)
                httc_pkg::MODE_MODIFY:
                begin
                    if (hin == '0)
                    begin
                        for (i = httc_pkg::CHANNELS - 1; i >= 0; i--)
                            if (chan_handle[i] == '0)
                                c = i;
                        if (c < 0)
                        begin
                            due_results.push_back(reply(httc_pkg::ST_NOT_CREATED, '0));
                            return;
                        end
                    end
                    else if (top == 0 || top > httc_pkg::CHANNELS)
                    begin
                        due_results.push_back(reply(httc_pkg::ST_INVALID, hin));
                        return;
                    end
                    else
                        c = top - 1;
                    // a free channel starts again at generation zero
                    if (chan_handle[c] == '0)
                        chan_handle[c] = httc_pkg::HANDLE_W'(c + 1) << httc_pkg::CHAN_SHIFT;
                    h = ((chan_handle[c] + 1) & GEN_MASK) | (chan_handle[c] & ~GEN_MASK);
                    chan_handle[c] = h;
                    t = tns;
                    if (cont && t < min_cycle)
                        t = min_cycle;
                    if (!cont && t < min_single)
                        t = min_single;
                    cnt = t / httc_pkg::NS_W'(httc_pkg::NS_PER_COUNT);
                    if (cnt > httc_pkg::NS_W'(httc_pkg::MAX_COUNT))
                        due_results.push_back(reply(httc_pkg::ST_NOT_CREATED, h));
                    else
                    begin
                        chan_arg[c] = arg;
                        chan_periodic[c] = cont;
                        chan_target[c] = cnt[httc_pkg::TIMER_W-1:0];
                        chan_count[c] = '0;
                        chan_running[c] = 1'b1;
                        due_results.push_back(reply(httc_pkg::ST_OK, h));
                    end
                end
                httc_pkg::MODE_DELETE:
                begin
                    if (hin == '0)
                        due_results.push_back(reply(httc_pkg::ST_OK, '0));
                    else if (top == 0 || top > httc_pkg::CHANNELS)
                        due_results.push_back(reply(httc_pkg::ST_INVALID, hin));
                    else
                    begin
                        c = top - 1;
                        if (chan_handle[c] != hin)
                            due_results.push_back(reply(httc_pkg::ST_OK, hin));
                        else
                        begin
                            chan_handle[c] = '0;
                            chan_running[c] = 1'b0;
                            due_results.push_back(reply(httc_pkg::ST_OK, '0));
                        end
                    end
                end
                httc_pkg::MODE_TICK:
                begin
                    for (i = 0; i < httc_pkg::CHANNELS; i++)
                    begin
                        if (chan_running[i])
                        begin
                            nxt = {1'b0, chan_count[i]} + 1'b1;
                            if (nxt >= {1'b0, chan_target[i]})
                            begin
                                // channels beyond the event limit hold their count
                                if (n < httc_pkg::MAX_EVENTS)
                                begin
                                    ev.kind = httc_pkg::KIND_EXPIRY;
                                    ev.status = httc_pkg::ST_OK;
                                    ev.handle = chan_handle[i];
                                    ev.argument = chan_arg[i];
                                    ev.last = 1'b0;
                                    due_results.push_back(ev);
                                    n++;
                                    chan_count[i] = '0;
                                    if (!chan_periodic[i])
                                        chan_running[i] = 1'b0;
                                end
                            end
                            else
                                chan_count[i] = nxt[httc_pkg::TIMER_W-1:0];
                        end
                    end
                    if (n > 0)
                    begin
                        ev = due_results.pop_back();
                        ev.last = 1'b1;
                        due_results.push_back(ev);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(httc_pkg::result_t got);
            httc_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected item: kind %0d status %0d handle %h argument %h last %0d",
                         $time, got.kind, got.status, got.handle, got.argument, got.last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $display("%0t kind: expected %0d, actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.handle !== want.handle)
            begin
                $display("%0t handle_out: expected %h, actual %h", $time, want.handle, got.handle);
                errors++;
            end
            if (got.argument !== want.argument)
            begin
                $display("%0t argument_out: expected %h, actual %h",
                         $time, want.argument, got.argument);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t last: expected %0d, actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction

    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [1:0]                       mode = httc_pkg::MODE_TICK;
    logic [httc_pkg::HANDLE_W-1:0]    handle_in = '0;
    logic [httc_pkg::NS_W-1:0]        timeout_ns = '0;
    logic                             continuous = 1'b0;
    logic [httc_pkg::ARG_W-1:0]       argument = '0;
    logic                             cfg_wr_en = 1'b0;
    logic [httc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [httc_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             done;
    logic                             kind;
    logic [1:0]                       status;
    logic [httc_pkg::HANDLE_W-1:0]    handle_out;
    logic [httc_pkg::ARG_W-1:0]       argument_out;
    logic                             last;

    timer_bank_tracker sb = new();
    httc_pkg::result_t seen;
    int quiet_cycles = 0;

    handle_tagged_timer_channels u_top (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.kind = httc_pkg::kind_t'(kind);
            seen.status = httc_pkg::status_t'(status);
            seen.handle = handle_out;
            seen.argument = argument_out;
            seen.last = last;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(logic [1:0] md, logic [httc_pkg::HANDLE_W-1:0] h,
                             logic [httc_pkg::NS_W-1:0] t, logic c,
                             logic [httc_pkg::ARG_W-1:0] a);
        start <= 1'b1;
        mode <= md;
        handle_in <= h;
        timeout_ns <= t;
        continuous <= c;
        argument <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.take_command(md, h, t, c, a);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // wait out every outstanding item, plus a tick that may still be counting
    task automatic drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_limits(logic [httc_pkg::CFG_W-1:0] single_ns,
                                logic [httc_pkg::CFG_W-1:0] cycle_ns);
        logic [httc_pkg::CFG_W-1:0] vals [4];
        int i;
        vals[0] = single_ns;
        vals[1] = cycle_ns;
        vals[2] = $urandom;
        vals[3] = $urandom;
        cfg_wr_en <= 1'b1;
        for (i = 0; i < 4; i++)
        begin
            cfg_index <= httc_pkg::CFG_INDEX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(httc_pkg::CFG_INDEX_W'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [httc_pkg::HANDLE_W-1:0] pick_handle(int zero_pct);
        int r;
        int ch;
        r = $urandom_range(0, 99);
        ch = $urandom_range(0, httc_pkg::CHANNELS - 1);
        if (r < zero_pct)
            return '0;
        if (r < zero_pct + 45 && sb.chan_handle[ch] != '0)
            return sb.chan_handle[ch];
        if (r < zero_pct + 65)
            return {httc_pkg::TOP_W'(ch + 1), (httc_pkg::CHAN_SHIFT)'($urandom)};
        if (r < zero_pct + 75)
            return {httc_pkg::TOP_W'($urandom_range(httc_pkg::CHANNELS + 1, 15)),
                    (httc_pkg::CHAN_SHIFT)'($urandom)};
        if (r < zero_pct + 82)
            return {httc_pkg::TOP_W'(0),
                    (httc_pkg::CHAN_SHIFT)'($urandom_range(1, 32'h0FFF_FFFF))};
        return $urandom;
    endfunction

    function automatic logic [httc_pkg::NS_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 30000);
        if (r < 80)
            return $urandom_range(0, 300000);
        if (r < 90)
            return $urandom;
        return FIRST_OVER_NS - 3 + $urandom_range(0, 6);
    endfunction

    task automatic random_item(int idle_pct, output bit counted);
        int r;
        logic [1:0] md;
        logic [httc_pkg::HANDLE_W-1:0] h;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            md = httc_pkg::MODE_TICK;
            h = $urandom;
        end
        else if (r < 82)
        begin
            md = httc_pkg::MODE_MODIFY;
            h = pick_handle(30);
        end
        else if (r < 97)
        begin
            md = httc_pkg::MODE_DELETE;
            h = pick_handle(15);
        end
        else
        begin
            md = httc_pkg::MODE_UNUSED;
            h = $urandom;
        end
        send_item(md, h, pick_timeout(), 1'($urandom), $urandom);
        counted = (md != httc_pkg::MODE_UNUSED);
        if ($urandom_range(0, 99) < idle_pct)
            pause($urandom_range(1, 4));
        if ($urandom_range(0, 199) == 0)
            drain();
    endtask

    task automatic run_directed();
        send_item(httc_pkg::MODE_TICK, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(httc_pkg::MODE_MODIFY, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_MODIFY, '0, '0, 1'b1, 32'hFFFF_FFFF);
        // both channels taken
        send_item(httc_pkg::MODE_MODIFY, '0, 32'd10000, 1'b0, 32'h1234_5678);
        send_item(httc_pkg::MODE_MODIFY, 32'h3000_0000, 32'd10000, 1'b0, '0);
        send_item(httc_pkg::MODE_MODIFY, 32'hF000_0001, 32'd10000, 1'b1, '0);
        send_item(httc_pkg::MODE_MODIFY, 32'h0000_0005, 32'd10000, 1'b0, '0);
        // generation is not checked on modify; too long a timeout still advances it
        send_item(httc_pkg::MODE_MODIFY, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hDEAD_BEEF);
        send_item(httc_pkg::MODE_MODIFY, sb.chan_handle[0], FIRST_OVER_NS - 1, 1'b0,
                  32'h0F0F_0F0F);
        send_item(httc_pkg::MODE_MODIFY, sb.chan_handle[0], FIRST_OVER_NS, 1'b1,
                  32'hF0F0_F0F0);
        send_item(httc_pkg::MODE_MODIFY, sb.chan_handle[0], 32'd4608, 1'b0, 32'hA5A5_5A5A);
        send_item(httc_pkg::MODE_TICK, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_TICK, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, 32'hF000_0000, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, 32'h1000_0000, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, sb.chan_handle[0], '0, 1'b0, '0);
        // old handle of a free channel claims it again
        send_item(httc_pkg::MODE_MODIFY, 32'h1ABC_DEF0, 32'd20000, 1'b1, 32'h5555_AAAA);
        drain();
        write_limits('0, '0);
        // zero targets on both channels: two expiries from one tick
        send_item(httc_pkg::MODE_MODIFY, sb.chan_handle[0], '0, 1'b1, 32'h1111_2222);
        send_item(httc_pkg::MODE_MODIFY, sb.chan_handle[1], 32'd2303, 1'b0, 32'h3333_4444);
        send_item(httc_pkg::MODE_TICK, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_TICK, '0, '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, sb.chan_handle[1], '0, 1'b0, '0);
        send_item(httc_pkg::MODE_DELETE, sb.chan_handle[0], '0, 1'b0, '0);
    endtask

    initial
    begin
        int phase;
        int count;
        int idle_pct;
        bit counted;
        logic [httc_pkg::CFG_W-1:0] single_ns;
        logic [httc_pkg::CFG_W-1:0] cycle_ns;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: begin single_ns = '0; cycle_ns = '0; end
                1: begin single_ns = 32'd5000; cycle_ns = 32'd100000; end
                2: begin single_ns = '1; cycle_ns = '1; end
                3: begin single_ns = 32'd2304; cycle_ns = 32'd23040; end
                4:
                begin
                    single_ns = $urandom_range(0, 20000);
                    cycle_ns = $urandom_range(0, 60000);
                end
                5: begin single_ns = '0; cycle_ns = '1; end
                6: begin single_ns = '1; cycle_ns = '0; end
                default:
                begin
                    single_ns = $urandom_range(0, 9000);
                    cycle_ns = $urandom_range(0, 9000);
                end
            endcase
            write_limits(single_ns, cycle_ns);
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 47;
                default: idle_pct = 14;
            endcase
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                random_item(idle_pct, counted);
                if (counted)
                    count++;
            end
        end
        start <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (sb.due_results.size() != 0)
        begin
            $display("%0t %0d items never arrived", $time, sb.due_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
